[rtl/rtp_receive_ssrc_filter_core_assert.svh]
// ----------------------------------------------------------------------------
// RTP receive SSRC filter assertion macros
// Concurrent assertion shorthands used by the filter core.
// ----------------------------------------------------------------------------
`ifndef RTP_RECEIVE_SSRC_FILTER_CORE_ASSERT_SVH
`define RTP_RECEIVE_SSRC_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define RRSF_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define RRSF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rrsf_pkg.sv]
// ----------------------------------------------------------------------------
// RTP receive SSRC filter package
// Types, codes and constants shared by the filter modules.
// ----------------------------------------------------------------------------
package rrsf_pkg;

  localparam int unsigned MISMATCH_LIMIT_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF    = 2;

  localparam logic [7:0]  VERSION_MASK   = 8'hC0;
  localparam logic [7:0]  VERSION_RTP    = 8'h80;
  localparam logic [7:0]  PAD_MASK       = 8'h20;
  localparam logic [18:0] BASE_HDR_BYTES = 19'd12;
  localparam logic [18:0] EXT_HDR_BYTES  = 19'd4;
  localparam logic [3:0]  MISMATCH_MAX   = 4'hF;
  localparam logic [15:0] SEQ_HIGH_MARK  = 16'hC000;
  localparam logic [15:0] SEQ_LOW_MARK   = 16'h4000;

  typedef enum logic [1:0] {
    ACT_DROP_HDR  = 2'd0,
    ACT_DROP_SSRC = 2'd1,
    ACT_DELIVER   = 2'd2,
    ACT_RTCP      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_DEST_IP    = 2'd0,
    REG_DEST_PORT  = 2'd1,
    REG_TYPES_LOW  = 2'd2,
    REG_TYPES_HIGH = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_RTP  = 1'b0,
    CMD_RTCP = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [15:0] seq_num;
    logic [31:0] sync_source;
    logic [15:0] packet_length;
    logic [7:0]  last_byte;
    logic [15:0] ext_words;
    logic [31:0] src_ip;
    logic [15:0] src_port;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  payload_type;
    logic [7:0]  header_byte_out;
    logic [18:0] payload_offset;
    logic [15:0] payload_length;
    logic [15:0] content_length;
    logic [31:0] locked_source;
    logic [15:0] highest_seq;
    logic [15:0] seq_cycles;
  } out_item_t;

  typedef struct packed {
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [63:0] types_low;
    logic [63:0] types_high;
  } cfg_t;

  typedef struct packed {
    action_e     action;
    logic        check;
    logic [6:0]  payload_type;
    logic [7:0]  header_byte;
    logic [18:0] payload_offset;
    logic [15:0] payload_length;
    logic [15:0] content_length;
    logic [31:0] sync_source;
    logic [15:0] seq_num;
    logic        ip_match;
    logic        port_match;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

[rtl/rrsf_front.sv]
// ----------------------------------------------------------------------------
// RTP receive SSRC filter front end
// Parses one packet header and classifies it for the lock stage.
// ----------------------------------------------------------------------------
module rrsf_front import rrsf_pkg::*; (
  input  in_item_t in_data_i,
  input  cfg_t     cfg_i,
  output entry_t   entry_o
);

  always_comb begin
    logic [1:0]  pad;
    logic [15:0] clen;
    logic [18:0] off;
    logic [18:0] diff;
    logic [6:0]  pt;
    logic        type_ok;
    entry_t      e;

    e      = '0;
    pad    = 2'd0;
    pt     = in_data_i.second_byte[6:0];
    if (in_data_i.first_byte[5] && (in_data_i.last_byte[7:2] == 6'd0)) begin
      pad = in_data_i.last_byte[1:0];
    end
    clen = (in_data_i.packet_length >= {14'd0, pad}) ?
           (in_data_i.packet_length - {14'd0, pad}) : 16'd0;
    off  = BASE_HDR_BYTES + {13'd0, in_data_i.first_byte[3:0], 2'b00};
    if (in_data_i.first_byte[4]) begin
      off = off + {1'b0, in_data_i.ext_words, 2'b00} + EXT_HDR_BYTES;
    end
    diff    = {3'd0, clen} - off;
    type_ok = pt[6] ? cfg_i.types_high[pt[5:0]] : cfg_i.types_low[pt[5:0]];

    e.sync_source = in_data_i.sync_source;
    e.seq_num     = in_data_i.seq_num;
    e.ip_match    = (in_data_i.src_ip == cfg_i.dest_ip);
    e.port_match  = (in_data_i.src_port == cfg_i.dest_port);

    if (in_data_i.cmd == CMD_RTCP) begin
      e.action = ACT_RTCP;
    end else if ((in_data_i.first_byte & VERSION_MASK) != VERSION_RTP) begin
      e.action      = ACT_DROP_HDR;
      e.header_byte = in_data_i.first_byte;
    end else begin
      e.action         = ACT_DROP_HDR;
      e.check          = type_ok;
      e.payload_type   = pt;
      e.header_byte    = in_data_i.first_byte & ~PAD_MASK;
      e.payload_offset = off;
      e.content_length = clen;
      e.payload_length = ({3'd0, clen} >= off) ? diff[15:0] : 16'd0;
    end
    entry_o = e;
  end

endmodule

[rtl/rrsf_fifo.sv]
// ----------------------------------------------------------------------------
// RTP receive SSRC filter queue
// Short first-in first-out queue between the front end and the lock stage.
// ----------------------------------------------------------------------------
module rrsf_fifo import rrsf_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  entry_t       push_data_i,
  input  logic         pop_i,
  output entry_t       pop_data_o,
  output fifo_status_t status_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == FULL_CNT);
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/rrsf_back.sv]
// ----------------------------------------------------------------------------
// RTP receive SSRC filter lock stage
// Applies the SSRC lock and sequence tracking and holds the result register.
// ----------------------------------------------------------------------------
module rrsf_back import rrsf_pkg::*; #(
  parameter int unsigned MISMATCH_LIMIT = MISMATCH_LIMIT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  entry_t    entry_i,
  input  logic      entry_valid_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam logic [3:0] LIMIT = 4'(MISMATCH_LIMIT);

  logic [31:0] pref_source_q, pref_source_d;
  logic        pref_valid_q, pref_valid_d;
  logic [3:0]  mismatch_q, mismatch_d;
  logic [31:0] ip_only_q, ip_only_d;
  logic        ip_only_valid_q, ip_only_valid_d;
  logic [31:0] other_q, other_d;
  logic        other_valid_q, other_valid_d;
  logic [31:0] tracked_q, tracked_d;
  logic [15:0] max_seq_q, max_seq_d;
  logic [15:0] wrap_q, wrap_d;
  logic        out_valid_q;
  out_item_t   out_data_q, out_data_d;

  assign pop_o       = entry_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    logic [15:0] ms;
    logic [15:0] wc;
    action_e     act;

    pref_source_d   = pref_source_q;
    pref_valid_d    = pref_valid_q;
    mismatch_d      = mismatch_q;
    ip_only_d       = ip_only_q;
    ip_only_valid_d = ip_only_valid_q;
    other_d         = other_q;
    other_valid_d   = other_valid_q;
    tracked_d       = tracked_q;
    max_seq_d       = max_seq_q;
    wrap_d          = wrap_q;
    act             = entry_i.action;
    ms              = max_seq_q;
    wc              = wrap_q;

    if (entry_i.check) begin
      if (!pref_valid_q) begin
        pref_source_d   = entry_i.sync_source;
        pref_valid_d    = 1'b1;
        mismatch_d      = 4'd0;
        ip_only_valid_d = 1'b0;
        other_valid_d   = 1'b0;
      end
      if (entry_i.sync_source == pref_source_d) begin
        mismatch_d = 4'd0;
        act        = ACT_DELIVER;
        if (tracked_q != entry_i.sync_source) begin
          ms = entry_i.seq_num - 16'd1;
          wc = 16'd0;
        end
        tracked_d = entry_i.sync_source;
        if (ms < entry_i.seq_num) begin
          ms = entry_i.seq_num;
        end else if ((ms > SEQ_HIGH_MARK) && (entry_i.seq_num < SEQ_LOW_MARK)) begin
          wc = wc + 16'd1;
          ms = entry_i.seq_num;
        end
        max_seq_d = ms;
        wrap_d    = wc;
      end else begin
        act = ACT_DROP_SSRC;
        if (entry_i.ip_match && entry_i.port_match) begin
          pref_source_d   = entry_i.sync_source;
          pref_valid_d    = 1'b1;
          mismatch_d      = 4'd0;
          ip_only_valid_d = 1'b0;
          other_valid_d   = 1'b0;
        end else begin
          if (mismatch_d != MISMATCH_MAX) begin
            mismatch_d = mismatch_d + 4'd1;
          end
          if (entry_i.ip_match) begin
            ip_only_d       = entry_i.sync_source;
            ip_only_valid_d = 1'b1;
          end else begin
            other_d       = entry_i.sync_source;
            other_valid_d = 1'b1;
          end
          if (mismatch_d >= LIMIT) begin
            pref_source_d   = ip_only_valid_d ? ip_only_d : other_d;
            pref_valid_d    = 1'b1;
            mismatch_d      = 4'd0;
            ip_only_valid_d = 1'b0;
            other_valid_d   = 1'b0;
          end
        end
      end
    end

    out_data_d.action          = act;
    out_data_d.payload_type    = entry_i.payload_type;
    out_data_d.header_byte_out = entry_i.header_byte;
    out_data_d.payload_offset  = entry_i.payload_offset;
    out_data_d.payload_length  = entry_i.payload_length;
    out_data_d.content_length  = entry_i.content_length;
    out_data_d.locked_source   = pref_source_d;
    out_data_d.highest_seq     = max_seq_d;
    out_data_d.seq_cycles      = wrap_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pref_source_q   <= '0;
      pref_valid_q    <= 1'b0;
      mismatch_q      <= '0;
      ip_only_q       <= '0;
      ip_only_valid_q <= 1'b0;
      other_q         <= '0;
      other_valid_q   <= 1'b0;
      tracked_q       <= '0;
      max_seq_q       <= '0;
      wrap_q          <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (pop_o) begin
        pref_source_q   <= pref_source_d;
        pref_valid_q    <= pref_valid_d;
        mismatch_q      <= mismatch_d;
        ip_only_q       <= ip_only_d;
        ip_only_valid_q <= ip_only_valid_d;
        other_q         <= other_d;
        other_valid_q   <= other_valid_d;
        tracked_q       <= tracked_d;
        max_seq_q       <= max_seq_d;
        wrap_q          <= wrap_d;
        out_valid_q     <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

[rtl/rtp_receive_ssrc_filter_core.sv]
// ----------------------------------------------------------------------------
// RTP receive SSRC filter core
// Checks RTP headers, locates the payload and locks onto one SSRC.
// ----------------------------------------------------------------------------
// One packet header enters per transfer on the input channel (in_valid_i,
// in_stall_o, in_data_i) and yields exactly one result transfer on the output
// channel (out_valid_o, out_stall_i, out_data_o), in order.
// The front end parses and classifies a header in the cycle it is taken and
// writes it into a short queue. The lock stage takes one queue entry per
// cycle unless the result register is held by a stalled receiver, updates
// the SSRC lock and sequence state, and loads the result register. A result
// passes through the queue and the result register before it is offered,
// and a new header can be taken every cycle while the queue is not full.
// Once the queue is full, in_stall_o rises until the receiver takes a result.
// Configuration writes (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
// are always accepted and must only be made while the block is idle.
// Reset clears the configuration registers, the lock and sequence state,
// the queue and the valid flag of the result register.
// ----------------------------------------------------------------------------
`include "rtp_receive_ssrc_filter_core_assert.svh"

module rtp_receive_ssrc_filter_core import rrsf_pkg::*; #(
  parameter int unsigned MISMATCH_LIMIT = MISMATCH_LIMIT_DEF,
  parameter int unsigned QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  cfg_t         cfg_q;
  entry_t       front_entry;
  entry_t       head_entry;
  fifo_status_t fifo_status;
  logic         pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = fifo_status.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_DEST_IP:    cfg_q.dest_ip    <= cfg_data_i[31:0];
        REG_DEST_PORT:  cfg_q.dest_port  <= cfg_data_i[15:0];
        REG_TYPES_LOW:  cfg_q.types_low  <= cfg_data_i;
        REG_TYPES_HIGH: cfg_q.types_high <= cfg_data_i;
      endcase
    end
  end

  rrsf_front u_front (
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .entry_o   (front_entry)
  );

  rrsf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_entry),
    .pop_i       (pop),
    .pop_data_o  (head_entry),
    .status_o    (fifo_status)
  );

  rrsf_back #(
    .MISMATCH_LIMIT (MISMATCH_LIMIT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (head_entry),
    .entry_valid_i (!fifo_status.empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

  `RRSF_ASSERT_NEXT(a_push_fills_queue, clk_i, rst_ni, in_valid_i && !in_stall_o, !fifo_status.empty, "accepted header did not reach the queue")
  `RRSF_ASSERT_NEXT(a_pop_loads_result, clk_i, rst_ni, pop, out_valid_o, "queue entry taken without a result")
  `RRSF_ASSERT_IMPLIES(a_deliver_header_ok, clk_i, rst_ni, out_valid_o && (out_data_o.action == ACT_DELIVER), (out_data_o.header_byte_out[7:6] == 2'b10) && !out_data_o.header_byte_out[5], "delivered packet with bad header byte")

endmodule

[tb/sv/rtp_receive_ssrc_filter_core_tb.sv]
// ----------------------------------------------------------------------------
// RTP receive SSRC filter core testbench
// Sends directed and random packet headers through the filter core under
// several register settings, with random gaps on both channels and two long
// receiver hold-offs. A behavioral model of the header checks, the SSRC lock
// and the sequence tracking predicts every result, and each result transfer
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rtp_receive_ssrc_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrsf_pkg::*;

  localparam logic [31:0] HOME_IP    = 32'hC0A8_0001;
  localparam logic [15:0] HOME_PORT  = 16'd5004;
  localparam logic [31:0] FOREIGN_IP = 32'h0A00_0063;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i  = '0;

  in_item_t    packets_to_send [$];
  out_item_t   results_due [$];
  int unsigned packets_sent = 0;
  int unsigned mismatch_total = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  logic        hold_off = 1'b0;

  logic [31:0] dest_ip_cfg = '0;
  logic [15:0] dest_port_cfg = '0;
  logic [63:0] types_low_cfg = '0;
  logic [63:0] types_high_cfg = '0;

  logic [31:0] lock_ssrc = '0;
  logic        lock_valid = 1'b0;
  logic [3:0]  miss_count = '0;
  logic [31:0] ip_only_ssrc = '0;
  logic        ip_only_ok = 1'b0;
  logic [31:0] other_ssrc = '0;
  logic        other_ok = 1'b0;
  logic [31:0] track_ssrc = '0;
  logic [15:0] seq_max = '0;
  logic [15:0] seq_wraps = '0;

  logic [31:0] stream_ssrc [4];
  logic [15:0] stream_seq [4];

  rtp_receive_ssrc_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic type_enabled(logic [6:0] pt);
    return pt[6] ? types_high_cfg[pt[5:0]] : types_low_cfg[pt[5:0]];
  endfunction

  function automatic void lock_onto(logic [31:0] ssrc);
    lock_ssrc  = ssrc;
    lock_valid = 1'b1;
    miss_count = '0;
    ip_only_ok = 1'b0;
    other_ok   = 1'b0;
  endfunction

  function automatic out_item_t filter_packet(in_item_t pkt);
    out_item_t   res;
    logic [15:0] pad;
    logic [18:0] off;
    res = '0;
    if (pkt.cmd == CMD_RTCP) begin
      res.action = ACT_RTCP;
    end else if (pkt.first_byte[7:6] != 2'b10) begin
      res.action = ACT_DROP_HDR;
      res.header_byte_out = pkt.first_byte;
    end else begin
      res.payload_type = pkt.second_byte[6:0];
      res.header_byte_out = {pkt.first_byte[7:6], 1'b0, pkt.first_byte[4:0]};
      pad = (pkt.first_byte[5] && pkt.last_byte[7:2] == 6'd0) ? {8'd0, pkt.last_byte} : 16'd0;
      res.content_length = (pkt.packet_length >= pad) ? pkt.packet_length - pad : 16'd0;
      off = 19'd12 + {13'd0, pkt.first_byte[3:0], 2'b00};
      if (pkt.first_byte[4]) begin
        off = off + {1'b0, pkt.ext_words, 2'b00} + 19'd4;
      end
      res.payload_offset = off;
      res.payload_length = ({3'd0, res.content_length} >= off) ?
                           16'({3'd0, res.content_length} - off) : 16'd0;
      if (!type_enabled(res.payload_type)) begin
        res.action = ACT_DROP_HDR;
      end else begin
        if (!lock_valid) begin
          lock_onto(pkt.sync_source);
        end
        if (pkt.sync_source == lock_ssrc) begin
          res.action = ACT_DELIVER;
          miss_count = '0;
          if (track_ssrc != pkt.sync_source) begin
            track_ssrc = pkt.sync_source;
            seq_max    = pkt.seq_num - 16'd1;
            seq_wraps  = '0;
          end
          if (pkt.seq_num > seq_max) begin
            seq_max = pkt.seq_num;
          end else if (seq_max > SEQ_HIGH_MARK && pkt.seq_num < SEQ_LOW_MARK) begin
            seq_wraps = seq_wraps + 16'd1;
            seq_max   = pkt.seq_num;
          end
        end else begin
          res.action = ACT_DROP_SSRC;
          if (pkt.src_ip == dest_ip_cfg && pkt.src_port == dest_port_cfg) begin
            lock_onto(pkt.sync_source);
          end else begin
            if (miss_count != MISMATCH_MAX) begin
              miss_count = miss_count + 4'd1;
            end
            if (pkt.src_ip == dest_ip_cfg) begin
              ip_only_ssrc = pkt.sync_source;
              ip_only_ok   = 1'b1;
            end else begin
              other_ssrc = pkt.sync_source;
              other_ok   = 1'b1;
            end
            if (miss_count >= MISMATCH_LIMIT_DEF) begin
              lock_onto(ip_only_ok ? ip_only_ssrc : other_ssrc);
            end
          end
        end
      end
    end
    res.locked_source = lock_ssrc;
    res.highest_seq   = seq_max;
    res.seq_cycles    = seq_wraps;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t rtp_hdr(logic [7:0] b0, logic [7:0] b1, logic [15:0] seq,
                                       logic [31:0] ssrc, logic [15:0] plen,
                                       logic [7:0] lastb, logic [15:0] xw,
                                       logic [31:0] sip, logic [15:0] sport);
    in_item_t p;
    p.cmd           = CMD_RTP;
    p.first_byte    = b0;
    p.second_byte   = b1;
    p.seq_num       = seq;
    p.sync_source   = ssrc;
    p.packet_length = plen;
    p.last_byte     = lastb;
    p.ext_words     = xw;
    p.src_ip        = sip;
    p.src_port      = sport;
    return p;
  endfunction

  function automatic in_item_t stream_packet(int unsigned src, logic [31:0] sip,
                                             logic [15:0] sport);
    in_item_t   p;
    logic [6:0] pt;
    pt = 7'($urandom);
    for (int k = 0; k < 16 && !type_enabled(pt); k++) begin
      pt = 7'($urandom);
    end
    p.cmd           = ($urandom_range(0, 15) == 0) ? CMD_RTCP : CMD_RTP;
    p.first_byte    = {2'b10, ($urandom_range(0, 5) == 0), ($urandom_range(0, 5) == 0),
                       4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0)};
    p.second_byte   = {1'($urandom), pt};
    p.seq_num       = stream_seq[src];
    p.sync_source   = stream_ssrc[src];
    p.packet_length = 16'($urandom_range(0, 1500));
    p.last_byte     = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    p.ext_words     = 16'($urandom_range(0, 15));
    p.src_ip        = sip;
    p.src_port      = sport;
    case ($urandom_range(0, 19))
      0: stream_seq[src] = 16'($urandom);
      1: stream_seq[src] = stream_seq[src] - 16'($urandom_range(1, 20));
      default: stream_seq[src] = stream_seq[src] + 16'd1;
    endcase
    return p;
  endfunction

  task automatic queue_traffic(int unsigned count);
    logic [159:0] raw;
    int unsigned  run_left;
    int unsigned  src;
    int unsigned  pick;
    int unsigned  where;
    logic [31:0]  sip;
    logic [15:0]  sport;
    for (int i = 0; i < 4; i++) begin
      stream_ssrc[i] = $urandom;
      stream_seq[i]  = $urandom_range(0, 1) ? 16'($urandom_range(16'hFF00, 16'hFFFF))
                                            : 16'($urandom);
    end
    run_left = 0;
    src = 0;
    sip = '0;
    sport = '0;
    for (int unsigned n = 0; n < count; n++) begin
      if (run_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
          packets_to_send.push_back(raw[$bits(in_item_t)-1:0]);
          continue;
        end
        run_left = (pick < 22) ? $urandom_range(6, 10) : 1;
        src = (pick < 22 || pick >= 85) ? $urandom_range(1, 3) : 0;
        where = (run_left > 1) ? $urandom_range(1, 9) : $urandom_range(0, 9);
        if (where == 0) begin
          sip = dest_ip_cfg;
          sport = dest_port_cfg;
        end else if (where < 4) begin
          sip = dest_ip_cfg;
          sport = dest_port_cfg ^ 16'($urandom_range(1, 65535));
        end else begin
          sip = $urandom;
          sport = 16'($urandom);
          if (sip == dest_ip_cfg) sip = ~sip;
        end
      end
      run_left--;
      packets_to_send.push_back(stream_packet(src, sip, sport));
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_DEST_IP:   dest_ip_cfg    = value[31:0];
      REG_DEST_PORT: dest_port_cfg  = value[15:0];
      REG_TYPES_LOW: types_low_cfg  = value;
      default:       types_high_cfg = value;
    endcase
  endtask

  task automatic configure(logic [31:0] ip, logic [15:0] port, logic [63:0] lo,
                           logic [63:0] hi);
    write_reg(REG_DEST_IP, {32'd0, ip});
    write_reg(REG_DEST_PORT, {48'd0, port});
    write_reg(REG_TYPES_LOW, lo);
    write_reg(REG_TYPES_HIGH, hi);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (packets_to_send.size() != 0 || in_valid_i || results_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        results_due.push_back(filter_packet(in_data_i));
        packets_sent <= packets_sent + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (packets_to_send.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= packets_to_send.pop_front();
          send_gap <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: result transfer with nothing expected, got %h", $time, out_data_o);
          mismatch_total++;
        end else begin
          want = results_due.pop_front();
          check_field("action", 64'(want.action), 64'(out_data_o.action));
          check_field("payload_type", 64'(want.payload_type), 64'(out_data_o.payload_type));
          check_field("header_byte_out", 64'(want.header_byte_out),
                      64'(out_data_o.header_byte_out));
          check_field("payload_offset", 64'(want.payload_offset),
                      64'(out_data_o.payload_offset));
          check_field("payload_length", 64'(want.payload_length),
                      64'(out_data_o.payload_length));
          check_field("content_length", 64'(want.content_length),
                      64'(out_data_o.content_length));
          check_field("locked_source", 64'(want.locked_source), 64'(out_data_o.locked_source));
          check_field("highest_seq", 64'(want.highest_seq), 64'(out_data_o.highest_seq));
          check_field("seq_cycles", 64'(want.seq_cycles), 64'(out_data_o.seq_cycles));
        end
        stall_left = pick_gap();
      end
      if (hold_off || stall_left != 0) begin
        out_stall_i <= 1'b1;
        if (stall_left != 0) stall_left = stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : receiver_hold
    for (int k = 0; k < 2; k++) begin
      do @(posedge clk_i); while (packets_sent < ((k == 0) ? 150 : 700));
      hold_off <= 1'b1;
      repeat (300) @(posedge clk_i);
      hold_off <= 1'b0;
    end
  end

  initial begin : watchdog
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(HOME_IP, HOME_PORT, 64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0001);
    packets_to_send.push_back('1);
    packets_to_send.push_back(rtp_hdr(8'h00, 8'h01, '0, '0, '0, '0, '0, '0, '0));
    packets_to_send.push_back(rtp_hdr(8'hFF, 8'hFF, '1, '1, '1, '1, '1, '1, '1));
    packets_to_send.push_back(rtp_hdr(8'h40, 8'h01, 16'd7, 32'h1111_1111, 16'd80, '0, '0,
                                      FOREIGN_IP, 16'd7000));
    packets_to_send.push_back(rtp_hdr(8'h80, 8'h00, 16'd1, 32'h1111_1111, 16'd200, '0, '0,
                                      FOREIGN_IP, 16'd7000));
    packets_to_send.push_back(rtp_hdr(8'h80, 8'hC1, 16'd1, 32'h1111_1111, 16'd200, '0, '0,
                                      FOREIGN_IP, 16'd7000));
    packets_to_send.push_back(rtp_hdr(8'h80, 8'h01, 16'hFFFE, 32'h1111_1111, 16'd200, '0, '0,
                                      FOREIGN_IP, 16'd7000));
    packets_to_send.push_back(rtp_hdr(8'hBF, 8'hFF, 16'hFFFF, 32'h1111_1111, 16'hFFFF, 8'h03,
                                      16'hFFFF, FOREIGN_IP, 16'd7000));
    packets_to_send.push_back(rtp_hdr(8'h90, 8'h40, 16'h0002, 32'h1111_1111, 16'd40, '0,
                                      16'd2, FOREIGN_IP, 16'd7000));
    packets_to_send.push_back(rtp_hdr(8'hA0, 8'h01, 16'h0003, 32'h1111_1111, 16'd100, 8'h04,
                                      '0, FOREIGN_IP, 16'd7000));
    packets_to_send.push_back(rtp_hdr(8'hA3, 8'h01, 16'h0004, 32'h1111_1111, 16'd2, 8'h03,
                                      '0, FOREIGN_IP, 16'd7000));
    packets_to_send.push_back(rtp_hdr(8'h80, 8'h7F, 16'h0004, 32'h1111_1111, 16'd0, 8'hFF,
                                      '0, FOREIGN_IP, 16'd7000));
    packets_to_send.push_back(rtp_hdr(8'h80, 8'h01, 16'd0, 32'hFFFF_FFFF, 16'd60, '0, '0,
                                      HOME_IP, HOME_PORT));
    packets_to_send.push_back(rtp_hdr(8'h80, 8'h01, 16'h1234, 32'hFFFF_FFFF, 16'd60, '0, '0,
                                      FOREIGN_IP, 16'd7000));
    for (int k = 0; k < 8; k++) begin
      packets_to_send.push_back((k < 4) ?
        rtp_hdr(8'h80, 8'h01, 16'(k), 32'h0000_0000, 16'd60, '0, '0, HOME_IP, 16'd5005) :
        rtp_hdr(8'h80, 8'h01, 16'(k), 32'h5555_AAAA, 16'd60, '0, '0, FOREIGN_IP, 16'd7000));
    end
    packets_to_send.push_back(rtp_hdr(8'h80, 8'h01, 16'h8000, 32'h0000_0000, 16'd60, '0, '0,
                                      HOME_IP, 16'd5005));
    packets_to_send.push_back(rtp_hdr(8'h80, 8'h01, 16'h7000, 32'h0000_0000, 16'd60, '0, '0,
                                      HOME_IP, 16'd5005));
    wait_idle();

    configure($urandom, 16'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
    queue_traffic(250);
    wait_idle();

    configure(32'hFFFF_FFFF, 16'hFFFF, '1, '1);
    queue_traffic(200);
    wait_idle();

    configure('0, '0, '0, '0);
    queue_traffic(60);
    wait_idle();

    configure($urandom, 16'($urandom), '1, '0);
    queue_traffic(250);
    wait_idle();

    configure($urandom, 16'($urandom), '0, {$urandom, $urandom});
    queue_traffic(250);
    wait_idle();

    configure($urandom, 16'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
    queue_traffic(240);
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (mismatch_total == 0 && results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/rrsf_pkg.sv
rtl/rrsf_front.sv
rtl/rrsf_fifo.sv
rtl/rrsf_back.sv
rtl/rtp_receive_ssrc_filter_core.sv
tb/sv/rtp_receive_ssrc_filter_core_tb.sv
